@@ rtl/fbdo_pkg.sv @@
// fbdo_pkg: shared types and constants for the four button debouncer with oneshot
// no dependencies
`default_nettype none

package fbdo_pkg;

    localparam int DELAY_W = 32;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd20;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_CLEAR = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        PH_UP      = 2'd0,
        PH_BOUNCE  = 2'd1,
        PH_ONESHOT = 2'd2,
        PH_DOWN    = 2'd3
    } t_phase;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_btn_ctl;

endpackage

`default_nettype wire

@@ rtl/fbdo_btn.sv @@
// fbdo_btn: one debouncer cell, phase machine plus held and oneshot flags
// depends on fbdo_pkg
`default_nettype none

module fbdo_btn #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fbdo_pkg::t_btn_ctl            i_ctl,
    input  wire logic                          i_level,
    input  wire logic [TIME_WIDTH-1:0]         i_now,
    input  wire logic [fbdo_pkg::DELAY_W-1:0]  i_delay,
    output logic                               o_held,
    output logic                               o_pulse
);
    import fbdo_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > DELAY_W) ? TIME_WIDTH : DELAY_W;

    t_phase                r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_start, n_start;
    logic                  r_held, n_held;
    logic                  r_pulse, n_pulse;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  expired;

    assign elapsed = i_now - r_start;
    assign expired = CMP_W'(elapsed) > CMP_W'(i_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UP;
            r_held  <= 1'b0;
            r_pulse <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pulse <= n_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_held  = r_held;
        n_pulse = r_pulse;
        if (i_ctl.tick) begin
            unique case (r_phase)
                PH_UP: begin
                    if (!i_level) begin
                        n_phase = PH_BOUNCE;
                    end
                    n_start = i_now;
                    n_held  = 1'b0;
                    n_pulse = 1'b0;
                end
                PH_BOUNCE: begin
                    if (i_level) begin
                        n_phase = PH_UP;
                    end else if (expired) begin
                        n_phase = PH_ONESHOT;
                    end
                end
                PH_ONESHOT: begin
                    n_phase = PH_DOWN;
                    n_pulse = 1'b1;
                end
                PH_DOWN: begin
                    if (i_level) begin
                        n_phase = PH_UP;
                    end else begin
                        n_held = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_UP;
                end
            endcase
        end else if (i_ctl.clear) begin
            n_pulse = 1'b0;
        end
    end

    assign o_held  = r_held;
    assign o_pulse = r_pulse;

endmodule

`default_nettype wire

@@ rtl/four_button_debounce_oneshot_top.sv @@
// four_button_debounce_oneshot_top: debouncer array with input register and flag outputs
// depends on fbdo_pkg and fbdo_btn
`default_nettype none

// Debounces NUM_BUTTONS active-low buttons against a free-running time count
// carried in each tick word; a clear word drops selected oneshot flags. One
// word is accepted per cycle while o_ready is high. An accepted word is held in
// the input register, then updates all button cells in parallel; the flag
// registers of the cells are the result and are shown with o_valid. A stalled
// result holds the input register, and the input side keeps taking words until
// that register is full. The user must write debounce_delay through i_cfg_we
// and i_cfg_wdata only while no word is in flight; the block does not enforce it.
module four_button_debounce_oneshot_top #(
    parameter int NUM_BUTTONS = 4,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire fbdo_pkg::t_cmd                i_cmd,
    input  wire logic [NUM_BUTTONS-1:0]        i_button_levels,
    input  wire logic [TIME_WIDTH-1:0]         i_time_now,
    input  wire logic [NUM_BUTTONS-1:0]        i_clear_mask,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [NUM_BUTTONS-1:0]             o_down_flags,
    output logic [NUM_BUTTONS-1:0]             o_oneshot_flags,
    input  wire logic                          i_cfg_we,
    input  wire logic [fbdo_pkg::DELAY_W-1:0]  i_cfg_wdata
);
    import fbdo_pkg::*;

    logic                   r_in_valid;
    t_cmd                   r_cmd;
    logic [NUM_BUTTONS-1:0] r_levels;
    logic [TIME_WIDTH-1:0]  r_time;
    logic [NUM_BUTTONS-1:0] r_mask;
    logic                   r_out_valid;
    logic [DELAY_W-1:0]     r_delay;
    logic                   advance;
    logic                   take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_delay     <= DELAY_RESET;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd    <= i_cmd;
            r_levels <= i_button_levels;
            r_time   <= i_time_now;
            r_mask   <= i_clear_mask;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        t_btn_ctl ctl;

        assign ctl.tick  = advance && (r_cmd == CMD_TICK);
        assign ctl.clear = advance && (r_cmd == CMD_CLEAR) && r_mask[g];

        fbdo_btn #(
            .TIME_WIDTH(TIME_WIDTH)
        ) u_btn (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_level (r_levels[g]),
            .i_now   (r_time),
            .i_delay (r_delay),
            .o_held  (o_down_flags[g]),
            .o_pulse (o_oneshot_flags[g])
        );
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/fbdo_checker.sv @@
// fbdo_checker: port-level checks on the debouncer top, bound to it below
// depends on four_button_debounce_oneshot_top
`default_nettype none

module fbdo_checker #(
    parameter int NUM_BUTTONS = 4
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_ready,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [NUM_BUTTONS-1:0] o_down_flags,
    input wire logic [NUM_BUTTONS-1:0] o_oneshot_flags
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_down_flags)
            && $stable(o_oneshot_flags))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // flags move only together with a new result word
    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid ##1 !o_valid |-> $stable(o_down_flags) && $stable(o_oneshot_flags))
        else $error("flags changed without a result word");

    // a free or draining output always frees the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled with output free");

endmodule

bind four_button_debounce_oneshot_top fbdo_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_fbdo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_down_flags    (o_down_flags),
    .o_oneshot_flags (o_oneshot_flags)
);

`default_nettype wire
